### hdl/route_label_forward_eval_top_macros.svh
// ---------------------------------------------------------------------------
// route_label_forward_eval_top_macros
// assertion macros for the forward label evaluator
// ---------------------------------------------------------------------------
`ifndef ROUTE_LABEL_FORWARD_EVAL_TOP_MACROS_SVH
`define ROUTE_LABEL_FORWARD_EVAL_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define RLFE_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define RLFE_ASSERT_RST(name, prop, msg) \
    name: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define RLFE_ASSERT(name, prop, msg)
`define RLFE_ASSERT_RST(name, prop, msg)
`endif

`endif

### hdl/rlfe_pkg.sv
// ---------------------------------------------------------------------------
// rlfe_pkg
// widths, register indexes, item types and saturation helper
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rlfe_pkg;

    localparam int TIME_BITS   = 24;
    localparam int ACC_BITS    = 32;
    localparam int CFG_BITS    = 24;
    localparam int WEIGHT_BITS = 32;
    localparam int FRAC_BITS   = 16;
    localparam int COST_BITS   = 48;
    localparam int WIDE_BITS   = ACC_BITS + 2;
    localparam int PROD_BITS   = ACC_BITS + WEIGHT_BITS;
    localparam int SUM_BITS    = PROD_BITS + 2;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 32;
    localparam int S_DATA_BITS = 7 * TIME_BITS;
    localparam int M_DATA_BITS = TIME_BITS + 6 * ACC_BITS + COST_BITS;

    localparam logic [CFG_IDX_BITS-1:0] REG_BATTERY_CAP  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_STORAGE_CAP  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_REPLENISH    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_OVERLOAD_W   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_LATENESS_W   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_OVERCHARGE_W = 3'd5;

    localparam logic [ACC_BITS-1:0]    ACC_MAX  = {ACC_BITS{1'b1}};
    localparam logic [COST_BITS-1:0]   COST_MAX = {COST_BITS{1'b1}};
    localparam logic [CFG_BITS-1:0]    CAP_RESET = {CFG_BITS{1'b1}};
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = WEIGHT_BITS'(1) << FRAC_BITS;

    typedef logic [WIDE_BITS-1:0] wide_t;
    typedef logic [PROD_BITS-1:0] prod_t;
    typedef logic [SUM_BITS-1:0]  sum_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] window_close;
        logic [TIME_BITS-1:0] window_open;
        logic [TIME_BITS-1:0] dwell_time;
        logic [TIME_BITS-1:0] demand;
        logic [TIME_BITS-1:0] energy_use;
        logic [TIME_BITS-1:0] arc_cost;
        logic [TIME_BITS-1:0] travel_time;
    } stop_t;

    typedef struct packed {
        logic [ACC_BITS-1:0]  overcharge_total;
        logic [ACC_BITS-1:0]  cum_time_warp;
        logic [ACC_BITS-1:0]  load_total;
        logic [ACC_BITS-1:0]  dist_total;
        logic [ACC_BITS-1:0]  residual_charge;
        logic [TIME_BITS-1:0] shifted_arrival;
        logic [ACC_BITS-1:0]  first_arrival;
    } label_t;

    function automatic logic [ACC_BITS-1:0] sat_acc(input wide_t v);
        logic [ACC_BITS-1:0] r;
        r = (v > wide_t'(ACC_MAX)) ? ACC_MAX : v[ACC_BITS-1:0];
        return r;
    endfunction

endpackage

### hdl/route_label_forward_eval_top.sv
// ---------------------------------------------------------------------------
// route_label_forward_eval_top
// forward label propagation along an electric-vehicle route
// ---------------------------------------------------------------------------
// Takes one stop word per cycle and returns one label word per stop, in order.
// The label (distance, load, arrival, residual charge, time warp, overcharge)
// is updated in the cycle the stop word is accepted, so stops may follow back
// to back at one word per cycle. The penalized cost then runs through three
// more stages (overload and Q16.16 weight multipliers, product sum, distance
// add with saturation), so each label word goes through st1, st2, st3 and
// the m_tvalid register. Each stage holds one word and moves on its own
// ready: while a finished word waits on m_tready the input keeps flowing until
// all four stages hold a word, then s_tready drops. Registers are written
// through the cfg port and must only change while no word is in flight.
`timescale 1ns / 1ps
`include "route_label_forward_eval_top_macros.svh"

module route_label_forward_eval_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [rlfe_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [rlfe_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // travel_time, arc_cost, energy_use, demand, dwell_time,
    // window_open, window_close
    input  logic [rlfe_pkg::S_DATA_BITS-1:0]     s_tdata,
    // route_start, at_station
    input  logic [1:0]                           s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // first_arrival, shifted_arrival, residual_charge, dist_total,
    // load_total, cum_time_warp, overcharge_total, penalized_cost
    output logic [rlfe_pkg::M_DATA_BITS-1:0]     m_tdata
);

    // configuration
    logic [rlfe_pkg::CFG_BITS-1:0]    battery_cap_reg;
    logic [rlfe_pkg::CFG_BITS-1:0]    storage_cap_reg;
    logic [rlfe_pkg::CFG_BITS-1:0]    replenish_reg;
    logic [rlfe_pkg::WEIGHT_BITS-1:0] overload_w_reg;
    logic [rlfe_pkg::WEIGHT_BITS-1:0] lateness_w_reg;
    logic [rlfe_pkg::WEIGHT_BITS-1:0] overcharge_w_reg;

    // label state
    logic [rlfe_pkg::ACC_BITS-1:0]  acc_distance_reg;
    logic [rlfe_pkg::ACC_BITS-1:0]  acc_load_reg;
    logic [rlfe_pkg::TIME_BITS-1:0] last_shifted_reg;
    logic [rlfe_pkg::ACC_BITS-1:0]  last_residual_reg;
    logic [rlfe_pkg::ACC_BITS-1:0]  acc_time_warp_reg;
    logic [rlfe_pkg::ACC_BITS-1:0]  acc_overcharge_reg;
    logic [rlfe_pkg::TIME_BITS-1:0] prev_service_reg;
    logic                           prev_station_reg;

    rlfe_pkg::stop_t  stop;
    rlfe_pkg::label_t label_next;
    logic             route_start;
    logic             at_station;
    logic             s_accept;

    rlfe_pkg::wide_t reach;
    rlfe_pkg::wide_t arrival_raw;
    rlfe_pkg::wide_t residual_raw;
    rlfe_pkg::wide_t wclose_w;
    logic [rlfe_pkg::ACC_BITS-1:0] arrival;
    logic [rlfe_pkg::ACC_BITS-1:0] residual;
    logic [rlfe_pkg::ACC_BITS-1:0] battery_cap_w;
    logic [rlfe_pkg::ACC_BITS-1:0] time_warp_next;
    logic [rlfe_pkg::ACC_BITS-1:0] overcharge_next;

    // pipeline
    logic                 st1_vld_reg;
    rlfe_pkg::label_t     st1_label_reg;
    logic                 st2_vld_reg;
    rlfe_pkg::label_t     st2_label_reg;
    rlfe_pkg::prod_t      st2_p_load_reg;
    rlfe_pkg::prod_t      st2_p_warp_reg;
    rlfe_pkg::prod_t      st2_p_over_reg;
    logic                 st3_vld_reg;
    rlfe_pkg::label_t     st3_label_reg;
    rlfe_pkg::sum_t       st3_sum_reg;
    logic                 m_vld_reg;
    rlfe_pkg::label_t     m_label_reg;
    logic [rlfe_pkg::COST_BITS-1:0] m_cost_reg;

    logic st1_ready, st2_ready, st3_ready, out_ready;
    logic [rlfe_pkg::ACC_BITS-1:0] overload;
    rlfe_pkg::sum_t cost_sum;
    logic [rlfe_pkg::COST_BITS-1:0] cost_next;

    assign stop        = rlfe_pkg::stop_t'(s_tdata);
    assign route_start = s_tuser[0];
    assign at_station  = s_tuser[1];

    assign out_ready = !m_vld_reg || m_tready;
    assign st3_ready = !st3_vld_reg || out_ready;
    assign st2_ready = !st2_vld_reg || st3_ready;
    assign st1_ready = !st1_vld_reg || st2_ready;
    assign s_tready  = st1_ready;
    assign s_accept  = s_tvalid && st1_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            battery_cap_reg  <= rlfe_pkg::CAP_RESET;
            storage_cap_reg  <= rlfe_pkg::CAP_RESET;
            replenish_reg    <= '0;
            overload_w_reg   <= rlfe_pkg::WEIGHT_ONE;
            lateness_w_reg   <= rlfe_pkg::WEIGHT_ONE;
            overcharge_w_reg <= rlfe_pkg::WEIGHT_ONE;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                rlfe_pkg::REG_BATTERY_CAP:  battery_cap_reg  <= cfg_wdata[rlfe_pkg::CFG_BITS-1:0];
                rlfe_pkg::REG_STORAGE_CAP:  storage_cap_reg  <= cfg_wdata[rlfe_pkg::CFG_BITS-1:0];
                rlfe_pkg::REG_REPLENISH:    replenish_reg    <= cfg_wdata[rlfe_pkg::CFG_BITS-1:0];
                rlfe_pkg::REG_OVERLOAD_W:   overload_w_reg   <= cfg_wdata;
                rlfe_pkg::REG_LATENESS_W:   lateness_w_reg   <= cfg_wdata;
                rlfe_pkg::REG_OVERCHARGE_W: overcharge_w_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // label update for the accepted stop
    always_comb begin
        battery_cap_w = rlfe_pkg::ACC_BITS'(battery_cap_reg);
        wclose_w      = rlfe_pkg::wide_t'(stop.window_close);
        reach = rlfe_pkg::wide_t'(last_shifted_reg) + rlfe_pkg::wide_t'(stop.travel_time)
              + rlfe_pkg::wide_t'(prev_service_reg);
        arrival_raw = (reach > rlfe_pkg::wide_t'(stop.window_open)) ? reach
                    : rlfe_pkg::wide_t'(stop.window_open);
        if (prev_station_reg) begin
            arrival_raw  = arrival_raw + rlfe_pkg::wide_t'(replenish_reg);
            residual_raw = rlfe_pkg::wide_t'(stop.energy_use);
        end else begin
            residual_raw = rlfe_pkg::wide_t'((last_residual_reg < battery_cap_w)
                         ? last_residual_reg : battery_cap_w)
                         + rlfe_pkg::wide_t'(stop.energy_use);
        end
        if (route_start) begin
            arrival_raw = rlfe_pkg::wide_t'(stop.window_open);
        end
        arrival  = rlfe_pkg::sat_acc(arrival_raw);
        residual = rlfe_pkg::sat_acc(residual_raw);

        time_warp_next = acc_time_warp_reg;
        if (rlfe_pkg::wide_t'(arrival) > wclose_w) begin
            time_warp_next = rlfe_pkg::sat_acc(rlfe_pkg::wide_t'(acc_time_warp_reg)
                           + rlfe_pkg::wide_t'(arrival) - wclose_w);
        end
        overcharge_next = acc_overcharge_reg;
        if (residual > battery_cap_w) begin
            overcharge_next = rlfe_pkg::sat_acc(rlfe_pkg::wide_t'(acc_overcharge_reg)
                            + rlfe_pkg::wide_t'(residual - battery_cap_w));
        end

        label_next.first_arrival   = arrival;
        label_next.shifted_arrival = (rlfe_pkg::wide_t'(arrival) < wclose_w)
                                   ? arrival[rlfe_pkg::TIME_BITS-1:0] : stop.window_close;
        if (route_start) begin
            label_next.residual_charge  = '0;
            label_next.dist_total       = '0;
            label_next.load_total       = rlfe_pkg::ACC_BITS'(stop.demand);
            label_next.cum_time_warp    = '0;
            label_next.overcharge_total = '0;
        end else begin
            label_next.residual_charge  = residual;
            label_next.dist_total       = rlfe_pkg::sat_acc(rlfe_pkg::wide_t'(acc_distance_reg)
                                        + rlfe_pkg::wide_t'(stop.arc_cost));
            label_next.load_total       = rlfe_pkg::sat_acc(rlfe_pkg::wide_t'(acc_load_reg)
                                        + rlfe_pkg::wide_t'(stop.demand));
            label_next.cum_time_warp    = time_warp_next;
            label_next.overcharge_total = overcharge_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_distance_reg   <= '0;
            acc_load_reg       <= '0;
            last_shifted_reg   <= '0;
            last_residual_reg  <= '0;
            acc_time_warp_reg  <= '0;
            acc_overcharge_reg <= '0;
            prev_service_reg   <= '0;
            prev_station_reg   <= 1'b0;
        end else if (s_accept) begin
            acc_distance_reg   <= label_next.dist_total;
            acc_load_reg       <= label_next.load_total;
            last_shifted_reg   <= label_next.shifted_arrival;
            last_residual_reg  <= label_next.residual_charge;
            acc_time_warp_reg  <= label_next.cum_time_warp;
            acc_overcharge_reg <= label_next.overcharge_total;
            prev_service_reg   <= stop.dwell_time;
            prev_station_reg   <= at_station;
        end
    end

    // cost pipeline
    assign overload = (st1_label_reg.load_total > rlfe_pkg::ACC_BITS'(storage_cap_reg))
                    ? st1_label_reg.load_total - rlfe_pkg::ACC_BITS'(storage_cap_reg) : '0;

    assign cost_sum = rlfe_pkg::sum_t'(st3_sum_reg >> rlfe_pkg::FRAC_BITS)
                    + rlfe_pkg::sum_t'(st3_label_reg.dist_total);
    assign cost_next = (cost_sum > rlfe_pkg::sum_t'(rlfe_pkg::COST_MAX)) ? rlfe_pkg::COST_MAX
                     : cost_sum[rlfe_pkg::COST_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_vld_reg <= 1'b0;
            st2_vld_reg <= 1'b0;
            st3_vld_reg <= 1'b0;
            m_vld_reg   <= 1'b0;
        end else begin
            if (st1_ready) st1_vld_reg <= s_tvalid;
            if (st2_ready) st2_vld_reg <= st1_vld_reg;
            if (st3_ready) st3_vld_reg <= st2_vld_reg;
            if (out_ready) m_vld_reg   <= st3_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            st1_label_reg <= label_next;
        end
        if (st2_ready && st1_vld_reg) begin
            st2_label_reg  <= st1_label_reg;
            st2_p_load_reg <= rlfe_pkg::prod_t'(overload) * rlfe_pkg::prod_t'(overload_w_reg);
            st2_p_warp_reg <= rlfe_pkg::prod_t'(st1_label_reg.cum_time_warp)
                            * rlfe_pkg::prod_t'(lateness_w_reg);
            st2_p_over_reg <= rlfe_pkg::prod_t'(st1_label_reg.overcharge_total)
                            * rlfe_pkg::prod_t'(overcharge_w_reg);
        end
        if (st3_ready && st2_vld_reg) begin
            st3_label_reg <= st2_label_reg;
            st3_sum_reg   <= rlfe_pkg::sum_t'(st2_p_load_reg) + rlfe_pkg::sum_t'(st2_p_warp_reg)
                           + rlfe_pkg::sum_t'(st2_p_over_reg);
        end
        if (out_ready && st3_vld_reg) begin
            m_label_reg <= st3_label_reg;
            m_cost_reg  <= cost_next;
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = {m_cost_reg, m_label_reg};

    `RLFE_ASSERT(a_start_clears,
        s_accept && route_start |=> acc_distance_reg == '0 && acc_time_warp_reg == '0
            && acc_overcharge_reg == '0,
        "route start did not clear label")
    `RLFE_ASSERT(a_station_residual,
        s_accept && !route_start && prev_station_reg
            |=> last_residual_reg == rlfe_pkg::ACC_BITS'($past(stop.energy_use)),
        "residual not restarted after station")
    `RLFE_ASSERT(a_cost_floor,
        m_vld_reg |-> rlfe_pkg::COST_BITS'(m_label_reg.dist_total) <= m_cost_reg,
        "cost below distance")
    `RLFE_ASSERT_RST(a_reset_empty,
        !aresetn |=> !m_vld_reg && !st1_vld_reg && !st2_vld_reg && !st3_vld_reg,
        "pipeline not empty after reset")

endmodule

### tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the forward route label evaluator
// ---------------------------------------------------------------------------
// Streams stop words through the block and predicts every label word from a
// local model of the forward label: distance, load, shifted arrival, residual
// charge, time warp, overcharge and the Q16.16 penalized cost. Covers directed
// corner stops, sweeps of the vehicle registers, long heavy routes that drive
// every accumulator and the cost into saturation, and random routes with noise,
// under random input gaps and output stalls.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    import rlfe_pkg::*;

    localparam int PIPE_DEPTH = 4;
    localparam int IDLE_LIMIT = 2000;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    typedef struct {
        label_t               lbl;
        logic [COST_BITS-1:0] cost;
    } label_word_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     cfg_wr_en = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [S_DATA_BITS-1:0]   s_tdata = '0;
    logic [1:0]               s_tuser = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [M_DATA_BITS-1:0]   m_tdata;

    // vehicle registers as the block holds them
    logic [CFG_BITS-1:0]    cap_battery = CAP_RESET;
    logic [CFG_BITS-1:0]    cap_storage = CAP_RESET;
    logic [CFG_BITS-1:0]    replenish_delay = '0;
    logic [WEIGHT_BITS-1:0] w_overload = WEIGHT_ONE;
    logic [WEIGHT_BITS-1:0] w_lateness = WEIGHT_ONE;
    logic [WEIGHT_BITS-1:0] w_overcharge = WEIGHT_ONE;

    // forward label carried between stops
    logic [ACC_BITS-1:0]  lbl_distance = '0;
    logic [ACC_BITS-1:0]  lbl_load = '0;
    logic [TIME_BITS-1:0] lbl_shifted = '0;
    logic [ACC_BITS-1:0]  lbl_residual = '0;
    logic [ACC_BITS-1:0]  lbl_time_warp = '0;
    logic [ACC_BITS-1:0]  lbl_overcharge = '0;
    logic [TIME_BITS-1:0] carry_service = '0;
    logic                 carry_station = 1'b0;

    label_word_t pending_labels[$];
    int unsigned failures = 0;
    int unsigned gap_max = 0;
    int unsigned stall_max = 0;
    int unsigned burst_left = 0;
    int unsigned hold_left = 0;

    route_label_forward_eval_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic logic [ACC_BITS-1:0] clamp_acc(input logic [63:0] v);
        return (v > 64'(ACC_MAX)) ? ACC_MAX : v[ACC_BITS-1:0];
    endfunction

    function automatic logic [TIME_BITS-1:0] clip_time(input logic [63:0] v);
        return (v > 64'(TIME_MAX)) ? TIME_MAX : v[TIME_BITS-1:0];
    endfunction

    function automatic label_word_t extend_label(input logic start, input logic station,
                                                 input stop_t st);
        logic [63:0] reach;
        logic [63:0] arrival;
        logic [63:0] res;
        logic [63:0] over;
        logic [95:0] total;
        label_word_t e;
        if (start) begin
            lbl_distance   = '0;
            lbl_load       = clamp_acc(64'(st.demand));
            arrival        = 64'(st.window_open);
            lbl_residual   = '0;
            lbl_time_warp  = '0;
            lbl_overcharge = '0;
        end else begin
            reach = 64'(lbl_shifted) + st.travel_time + carry_service;
            arrival = (reach > st.window_open) ? reach : 64'(st.window_open);
            if (carry_station) begin
                arrival = arrival + replenish_delay;
                res = 64'(st.energy_use);
            end else begin
                res = ((lbl_residual < cap_battery) ? 64'(lbl_residual) : 64'(cap_battery))
                      + st.energy_use;
            end
            arrival = 64'(clamp_acc(arrival));
            res = 64'(clamp_acc(res));
            lbl_distance = clamp_acc(64'(lbl_distance) + st.arc_cost);
            lbl_load = clamp_acc(64'(lbl_load) + st.demand);
            if (arrival > st.window_close)
                lbl_time_warp = clamp_acc(64'(lbl_time_warp) + (arrival - st.window_close));
            if (res > cap_battery)
                lbl_overcharge = clamp_acc(64'(lbl_overcharge) + (res - cap_battery));
            lbl_residual = res[ACC_BITS-1:0];
        end
        lbl_shifted = (arrival < st.window_close) ? arrival[TIME_BITS-1:0] : st.window_close;
        carry_service = st.dwell_time;
        carry_station = station;

        over = (lbl_load > cap_storage) ? 64'(lbl_load) - cap_storage : 64'd0;
        total = (96'(lbl_distance) << FRAC_BITS) + 96'(over) * 96'(w_overload)
                + 96'(lbl_time_warp) * 96'(w_lateness)
                + 96'(lbl_overcharge) * 96'(w_overcharge);
        total = total >> FRAC_BITS;

        e.lbl.first_arrival    = arrival[ACC_BITS-1:0];
        e.lbl.shifted_arrival  = lbl_shifted;
        e.lbl.residual_charge  = lbl_residual;
        e.lbl.dist_total       = lbl_distance;
        e.lbl.load_total       = lbl_load;
        e.lbl.cum_time_warp    = lbl_time_warp;
        e.lbl.overcharge_total = lbl_overcharge;
        e.cost = (total > 96'(COST_MAX)) ? COST_MAX : total[COST_BITS-1:0];
        return e;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failures++;
        end
    endfunction

    // label word checker
    always @(posedge aclk) begin : check_labels
        label_word_t want;
        label_t got;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_labels.size() == 0) begin
                $error("label word with no stop pending");
                failures++;
            end else begin
                want = pending_labels.pop_front();
                got = m_tdata[$bits(label_t)-1:0];
                check_field("first_arrival", 64'(want.lbl.first_arrival),
                            64'(got.first_arrival));
                check_field("shifted_arrival", 64'(want.lbl.shifted_arrival),
                            64'(got.shifted_arrival));
                check_field("residual_charge", 64'(want.lbl.residual_charge),
                            64'(got.residual_charge));
                check_field("dist_total", 64'(want.lbl.dist_total),
                            64'(got.dist_total));
                check_field("load_total", 64'(want.lbl.load_total), 64'(got.load_total));
                check_field("cum_time_warp", 64'(want.lbl.cum_time_warp),
                            64'(got.cum_time_warp));
                check_field("overcharge_total", 64'(want.lbl.overcharge_total),
                            64'(got.overcharge_total));
                check_field("penalized_cost", 64'(want.cost),
                            64'(m_tdata[M_DATA_BITS-1 -: COST_BITS]));
            end
        end
    end

    // receiver stall pattern
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
        end else if (stall_max == 0 || !m_tready) begin
            m_tready <= 1'b1;
            hold_left = $urandom_range(1, 24);
        end else begin
            m_tready <= 1'b0;
            hold_left = $urandom_range(1, stall_max);
        end
    end

    // watchdog on handshake activity
    initial begin : watchdog
        int unsigned idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle = 0;
            else
                idle++;
        end
        $display("route_label_forward_eval_top regression: fail");
        $finish;
    end

    task automatic send_stop(input logic start, input logic station, input stop_t st);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap != 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= st;
        s_tuser  <= {station, start};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_labels.push_back(extend_label(start, station, st));
    endtask

    task automatic wait_labels_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_labels.size() != 0) @(posedge aclk);
        repeat (PIPE_DEPTH + 4) @(posedge aclk);
        burst_left = 0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_BATTERY_CAP:  cap_battery = value[CFG_BITS-1:0];
            REG_STORAGE_CAP:  cap_storage = value[CFG_BITS-1:0];
            REG_REPLENISH:    replenish_delay = value[CFG_BITS-1:0];
            REG_OVERLOAD_W:   w_overload = value;
            REG_LATENESS_W:   w_lateness = value;
            REG_OVERCHARGE_W: w_overcharge = value;
            default: ;
        endcase
    endtask

    task automatic apply_vehicle_setup(input logic [31:0] battery, input logic [31:0] storage,
                                       input logic [31:0] replenish, input logic [31:0] wo,
                                       input logic [31:0] wl, input logic [31:0] wc);
        wait_labels_drained();
        write_reg(REG_BATTERY_CAP, battery);
        write_reg(REG_STORAGE_CAP, storage);
        write_reg(REG_REPLENISH, replenish);
        write_reg(REG_OVERLOAD_W, wo);
        write_reg(REG_LATENESS_W, wl);
        write_reg(REG_OVERCHARGE_W, wc);
    endtask

    function automatic logic [TIME_BITS-1:0] pick_time();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return TIME_MAX;
            2, 3, 4, 5: return TIME_BITS'($urandom_range(0, 1000));
            default: return TIME_BITS'($urandom);
        endcase
    endfunction

    function automatic stop_t make_stop(input logic [23:0] travel, input logic [23:0] cost,
                                        input logic [23:0] energy, input logic [23:0] demand,
                                        input logic [23:0] service, input logic [23:0] wopen,
                                        input logic [23:0] wclose);
        stop_t st;
        st.travel_time  = travel;
        st.arc_cost     = cost;
        st.energy_use   = energy;
        st.demand       = demand;
        st.dwell_time   = service;
        st.window_open  = wopen;
        st.window_close = wclose;
        return st;
    endfunction

    // windows mostly placed around the reachable arrival so waits and lateness both occur
    function automatic stop_t random_stop(input logic heavy);
        stop_t st;
        logic [63:0] reach;
        logic [63:0] base;
        st.travel_time  = pick_time();
        st.dwell_time   = pick_time();
        if (heavy) begin
            st.arc_cost     = TIME_BITS'($urandom_range(24'hF00000, 24'hFFFFFF));
            st.energy_use   = TIME_BITS'($urandom_range(24'hF00000, 24'hFFFFFF));
            st.demand       = TIME_BITS'($urandom_range(24'hF00000, 24'hFFFFFF));
            st.window_open  = '0;
            st.window_close = TIME_BITS'($urandom_range(0, 1000));
        end else begin
            st.arc_cost   = pick_time();
            st.energy_use = pick_time();
            st.demand     = pick_time();
            if ($urandom_range(0, 2) == 0) begin
                st.window_open  = pick_time();
                st.window_close = pick_time();
            end else begin
                reach = 64'(lbl_shifted) + st.travel_time + carry_service;
                base = (reach > 1500) ? reach - 1500 : 64'd0;
                st.window_open  = clip_time(base + $urandom_range(0, 3000));
                st.window_close = clip_time(64'(st.window_open) + $urandom_range(0, 3000));
            end
        end
        return st;
    endfunction

    task automatic drive_route(input int unsigned stops, input logic with_start,
                               input logic heavy);
        int unsigned i;
        for (i = 0; i < stops; i++)
            send_stop((i == 0) ? with_start : 1'b0, $urandom_range(0, 3) == 0,
                      random_stop(heavy));
    endtask

    task automatic test_directed_labels();
        // stop without a route start straight out of reset
        send_stop(1'b0, 1'b0, make_stop(0, 0, 0, 0, 0, 0, 0));
        send_stop(1'b0, 1'b1, make_stop(TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX,
                                        TIME_MAX, TIME_MAX));
        send_stop(1'b0, 1'b0, make_stop(100, 200, 300, 400, 50, 10, 20));
        // start with window open after close
        send_stop(1'b1, 1'b1, make_stop(TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX,
                                        TIME_MAX, 0));
        send_stop(1'b0, 1'b0, make_stop(TIME_MAX, 5, 5, 5, 0, 0, 1000));
        send_stop(1'b1, 1'b0, make_stop(7, 7, 7, 0, 0, 0, 0));
        send_stop(1'b0, 1'b0, make_stop(10, 1, 1, 1, 0, 5000, 6000));

        apply_vehicle_setup(1000, 500, TIME_MAX, '1, '1, '1);
        send_stop(1'b1, 1'b1, make_stop(1, 2, 3, 600, 40, 100, 200));
        // leaving a station: charge restarts, replenishment delay added
        send_stop(1'b0, 1'b0, make_stop(50, 10, 5000, 1, 10, 0, 300));
        send_stop(1'b0, 1'b0, make_stop(5, 10, 5000, 1, 0, 0, TIME_MAX));
        send_stop(1'b0, 1'b1, make_stop(5, 10, 0, 0, 0, 24'h800000, TIME_MAX));
        send_stop(1'b0, 1'b0, make_stop(TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX,
                                        TIME_MAX, 0));
        send_stop(1'b1, 1'b1, make_stop(TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX,
                                        TIME_MAX, TIME_MAX));
        send_stop(1'b0, 1'b1, make_stop(TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX,
                                        0, 0));
    endtask

    task automatic test_register_sweep();
        int unsigned k;
        int unsigned n;
        int unsigned len;
        for (k = 0; k < 5; k++) begin
            case (k)
                0: apply_vehicle_setup(0, 0, 0, 0, 0, 0);
                1: apply_vehicle_setup(TIME_MAX, TIME_MAX, TIME_MAX, '1, '1, '1);
                2: apply_vehicle_setup(CAP_RESET, CAP_RESET, 0, WEIGHT_ONE, WEIGHT_ONE,
                                       WEIGHT_ONE);
                default: apply_vehicle_setup($urandom, $urandom, $urandom, $urandom,
                                             $urandom, $urandom);
            endcase
            gap_max = (k % 2 == 0) ? 0 : 5;
            stall_max = (k % 3 == 0) ? 0 : 8;
            n = 0;
            while (n < 100) begin
                len = $urandom_range(1, 20);
                drive_route(len, $urandom_range(0, 7) != 0, 1'b0);
                n += len;
            end
        end
    endtask

    task automatic test_saturation();
        apply_vehicle_setup(0, 0, TIME_MAX, '1, '1, '1);
        gap_max = 2;
        stall_max = 3;
        drive_route(300, 1'b1, 1'b1);
        apply_vehicle_setup($urandom_range(0, 100000), $urandom_range(0, 100000), 1000,
                            $urandom_range(0, 65536), $urandom_range(0, 65536),
                            $urandom_range(0, 65536));
        gap_max = 0;
        stall_max = 0;
        drive_route(300, 1'b1, 1'b1);
    endtask

    task automatic test_random_routes();
        int unsigned seg;
        int unsigned n;
        int unsigned len;
        for (seg = 0; seg < 8; seg++) begin
            case (seg % 4)
                0: begin gap_max = 0; stall_max = 0; end
                1: begin gap_max = 4; stall_max = 0; end
                2: begin gap_max = 0; stall_max = 10; end
                default: begin gap_max = 8; stall_max = 6; end
            endcase
            // hold the input until every label word is back
            if (seg == 2)
                wait_labels_drained();
            if (seg == 4)
                apply_vehicle_setup($urandom_range(0, 20000), $urandom_range(0, 20000),
                                    $urandom_range(0, 500), $urandom, $urandom, $urandom);
            n = 0;
            while (n < 90) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 12);
                drive_route(len, $urandom_range(0, 9) != 0, 1'b0);
                n += len;
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_labels();
        test_register_sweep();
        test_saturation();
        test_random_routes();

        wait_labels_drained();
        if (failures == 0)
            $display("route_label_forward_eval_top regression: pass");
        else
            $display("route_label_forward_eval_top regression: fail");
        $finish;
    end

endmodule
